@@ sv/ipcf_pkg.sv @@
// ----------------------------------------------------------------------------
// ipcf_pkg
// shared types, constants and helpers of the imu pitch complementary filter
// ----------------------------------------------------------------------------
package ipcf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_CELLS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int CNT_W        = $clog2(CORDIC_CELLS + 1);
  localparam int SH_W         = 5;
  localparam int XY_W         = 32;
  localparam int ANG_W        = 26;

  localparam logic signed [ANG_W-1:0] Q16_180 = 26'sd11796480;
  localparam logic signed [27:0]      Q16_90  = 28'sd5898240;
  localparam logic signed [57:0]      DEG_SCALE = 58'sd1073820917;

  // register indexes
  localparam logic [2:0] REG_GYRO_OFFSET  = 3'd0;
  localparam logic [2:0] REG_ACCEL_Y_OFS  = 3'd1;
  localparam logic [2:0] REG_ACCEL_Z_OFS  = 3'd2;
  localparam logic [2:0] REG_GYRO_GAIN    = 3'd3;
  localparam logic [2:0] REG_BLEND_GAIN   = 3'd4;
  localparam logic [2:0] REG_CLAMP_WINDOW = 3'd5;
  localparam logic [2:0] REG_OUTPUT_BIAS  = 3'd6;

  typedef struct packed {
    logic signed [19:0] gyro_offset;
    logic signed [19:0] accel_y_offset;
    logic signed [19:0] accel_z_offset;
    logic        [23:0] gyro_step_gain;
    logic        [15:0] blend_gain;
    logic        [22:0] clamp_window;
    logic signed [23:0] output_bias;
  } cfg_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  v;
    logic signed [ANG_W-1:0] ang;
  } cordic_t;

  // arctangent of 2^-i in q16 degrees
  function automatic logic signed [ANG_W-1:0] atan_q16(input int idx);
    logic signed [ANG_W-1:0] r;
    case (idx)
      0:  r = 26'sd2949120;
      1:  r = 26'sd1740967;
      2:  r = 26'sd919879;
      3:  r = 26'sd466945;
      4:  r = 26'sd234379;
      5:  r = 26'sd117304;
      6:  r = 26'sd58666;
      7:  r = 26'sd29335;
      8:  r = 26'sd14668;
      9:  r = 26'sd7334;
      10: r = 26'sd3667;
      11: r = 26'sd1833;
      12: r = 26'sd917;
      13: r = 26'sd458;
      14: r = 26'sd229;
      15: r = 26'sd115;
      16: r = 26'sd57;
      17: r = 26'sd29;
      18: r = 26'sd14;
      19: r = 26'sd7;
      20: r = 26'sd4;
      21: r = 26'sd2;
      22: r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/ipcf_regs.sv @@
// ----------------------------------------------------------------------------
// ipcf_regs
// apb register bank holding offsets, gains, window and bias
// ----------------------------------------------------------------------------
module ipcf_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ipcf_pkg::cfg_t      cfg
);
  import ipcf_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gyro_offset    <= 20'sd24;
      cfg.accel_y_offset <= 20'sd24;
      cfg.accel_z_offset <= 20'sd160;
      cfg.gyro_step_gain <= 24'd10230;
      cfg.blend_gain     <= 16'd328;
      cfg.clamp_window   <= 23'd655360;
      cfg.output_bias    <= -24'sd262144;
    end else if (wr) begin
      unique case (idx)
        REG_GYRO_OFFSET:  cfg.gyro_offset    <= pwdata[19:0];
        REG_ACCEL_Y_OFS:  cfg.accel_y_offset <= pwdata[19:0];
        REG_ACCEL_Z_OFS:  cfg.accel_z_offset <= pwdata[19:0];
        REG_GYRO_GAIN:    cfg.gyro_step_gain <= pwdata[23:0];
        REG_BLEND_GAIN:   cfg.blend_gain     <= pwdata[15:0];
        REG_CLAMP_WINDOW: cfg.clamp_window   <= pwdata[22:0];
        REG_OUTPUT_BIAS:  cfg.output_bias    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GYRO_OFFSET:  prdata = {12'd0, cfg.gyro_offset};
      REG_ACCEL_Y_OFS:  prdata = {12'd0, cfg.accel_y_offset};
      REG_ACCEL_Z_OFS:  prdata = {12'd0, cfg.accel_z_offset};
      REG_GYRO_GAIN:    prdata = {8'd0, cfg.gyro_step_gain};
      REG_BLEND_GAIN:   prdata = {16'd0, cfg.blend_gain};
      REG_CLAMP_WINDOW: prdata = {9'd0, cfg.clamp_window};
      REG_OUTPUT_BIAS:  prdata = {8'd0, cfg.output_bias};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

@@ sv/ipcf_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// ipcf_cordic_cell
// one registered vectoring rotation with a fixed shift and arctangent
// ----------------------------------------------------------------------------
module ipcf_cordic_cell (
  input  logic                                 clk,
  input  logic [ipcf_pkg::SH_W-1:0]            shift,
  input  logic signed [ipcf_pkg::ANG_W-1:0]    atan,
  input  ipcf_pkg::cordic_t                    din,
  output ipcf_pkg::cordic_t                    dout
);
  import ipcf_pkg::*;

  logic signed [XY_W-1:0] xs, vs;

  assign xs = din.x >>> shift;
  assign vs = din.v >>> shift;

  always_ff @(posedge clk) begin
    if (din.v > 0) begin
      dout.x   <= din.x + vs;
      dout.v   <= din.v - xs;
      dout.ang <= din.ang + atan;
    end else begin
      dout.x   <= din.x - vs;
      dout.v   <= din.v + xs;
      dout.ang <= din.ang - atan;
    end
  end

endmodule

@@ sv/imu_pitch_complementary_filter_core.sv @@
// ----------------------------------------------------------------------------
// imu_pitch_complementary_filter_core
// sequence: input accept, gyro, the cordic rotation cells, scale, clamp, blend, update to result valid
// one item at a time: in_stall stays high until the state machine is back in idle
// the next item is taken once the result has moved into the output register
// reset: synchronous, clears control, pitch angle and registers to defaults
// ----------------------------------------------------------------------------
module imu_pitch_complementary_filter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] gyro_rate,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] fused_pitch
);
  import ipcf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_GYRO  = 7'b0000010,
    S_ROT   = 7'b0000100,
    S_SCALE = 7'b0001000,
    S_CLAMP = 7'b0010000,
    S_BLEND = 7'b0100000,
    S_UPD   = 7'b1000000
  } state_t;

  state_t state, state_next;
  cfg_t   cfg;

  logic [CNT_W-1:0]   cnt;
  logic signed [20:0] rate, ya, za;
  logic               acc_zero;
  logic signed [45:0] gprod;
  logic signed [57:0] mprod;
  logic signed [23:0] err;
  logic signed [40:0] bprod;
  logic signed [31:0] pitch_angle;

  // corrected samples, raw * 16 - offset
  logic signed [20:0] rate_c, ya_c, za_c;
  assign rate_c = {gyro_rate[15], gyro_rate, 4'd0} - 21'(cfg.gyro_offset);
  assign ya_c   = {accel_y[15], accel_y, 4'd0} - 21'(cfg.accel_y_offset);
  assign za_c   = {accel_z[15], accel_z, 4'd0} - 21'(cfg.accel_z_offset);

  ipcf_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  // cordic chain: cin feeds cell 0, each cell hands its vector on every cycle
  cordic_t chain [CORDIC_CELLS+1];
  cordic_t cin;
  assign chain[0] = cin;

  for (genvar i = 0; i < CORDIC_CELLS; i++) begin : g_cell
    ipcf_cordic_cell u_cell (
      .clk,
      .shift (SH_W'(i)),
      .atan  (atan_q16(i)),
      .din   (chain[i]),
      .dout  (chain[i+1])
    );
  end

  // prescale by 256, reflect left half plane
  logic signed [XY_W-1:0] x0, v0;
  assign x0 = XY_W'(za) <<< 8;
  assign v0 = XY_W'(ya) <<< 8;

  // accel pitch after scaling, the +-90 clamp and the window clamp around the pitch angle
  logic signed [57:0] msh;
  logic signed [27:0] acc_deg, acc_cl;
  logic signed [33:0] hi, lo, acc_w, pa34;
  assign msh     = mprod >>> 30;
  assign acc_deg = acc_zero ? 28'sd0 : 28'(-msh);
  always_comb begin
    if (acc_deg > Q16_90) begin
      acc_cl = Q16_90;
    end else if (acc_deg < -Q16_90) begin
      acc_cl = -Q16_90;
    end else begin
      acc_cl = acc_deg;
    end
  end
  assign pa34 = 34'(pitch_angle);
  assign hi   = pa34 + $signed({11'd0, cfg.clamp_window});
  assign lo   = pa34 - $signed({11'd0, cfg.clamp_window});
  always_comb begin
    if (34'(acc_cl) >= hi) begin
      acc_w = hi;
    end else if (34'(acc_cl) <= lo) begin
      acc_w = lo;
    end else begin
      acc_w = 34'(acc_cl);
    end
  end

  // rounded increments
  logic signed [45:0] ginc;
  logic signed [40:0] binc;
  logic signed [31:0] pitch_blend;
  assign ginc        = (gprod + 46'sd2048) >>> 12;
  assign binc        = (bprod + 41'sd32768) >>> 16;
  assign pitch_blend = sat32(36'(pitch_angle) + 36'(binc));

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_GYRO;
      S_GYRO:  state_next = S_ROT;
      S_ROT:   if (cnt == CNT_W'(CORDIC_CELLS - 1)) state_next = S_SCALE;
      S_SCALE: state_next = S_CLAMP;
      S_CLAMP: state_next = S_BLEND;
      S_BLEND: state_next = S_UPD;
      S_UPD:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      pitch_angle <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ROT) begin
        cnt <= cnt + 1'b1;
        // gyro integration lands while the chain works
        if (cnt == '0) pitch_angle <= sat32(36'(pitch_angle) + 36'(ginc));
      end else begin
        cnt <= '0;
      end
      // a new result refills the output register as the old one leaves
      if (state == S_UPD && (!out_valid || !out_stall)) begin
        pitch_angle <= pitch_blend;
        out_valid   <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        rate     <= rate_c;
        ya       <= ya_c;
        za       <= za_c;
        acc_zero <= (ya_c == '0) && (za_c == '0);
      end
      S_GYRO: begin
        gprod <= 46'(rate) * $signed({22'd0, cfg.gyro_step_gain});
        if (za < 0) begin
          cin.x   <= -x0;
          cin.v   <= -v0;
          cin.ang <= (ya >= 0) ? Q16_180 : -Q16_180;
        end else begin
          cin.x   <= x0;
          cin.v   <= v0;
          cin.ang <= '0;
        end
      end
      S_SCALE: mprod <= DEG_SCALE * 58'(chain[CORDIC_CELLS].ang);
      S_CLAMP: err   <= 24'(acc_w - pa34);
      S_BLEND: bprod <= 41'(err) * $signed({25'd0, cfg.blend_gain});
      S_UPD: begin
        if (!out_valid || !out_stall) begin
          fused_pitch <= sat32(36'(pitch_blend) + 36'(cfg.output_bias));
        end
      end
      default: ;
    endcase
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// checks the imu pitch complementary filter core item by item against a
// behavioral predictor of the gyro integration, accel tilt and blend
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ipcf_pkg::*;

  localparam longint CYCLE_LIMIT = 1000000;
  localparam longint TILT_180    = 11796480;
  localparam longint TILT_90     = 5898240;
  localparam longint RAD_TO_DEG  = 1073820917;
  // index past the register list, writes there change nothing
  localparam logic [2:0] REG_UNUSED = 3'd7;

  localparam longint ATAN_TBL [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [15:0] gyro;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } sample_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] gyro_rate = '0;
  logic signed [15:0] accel_y = '0;
  logic signed [15:0] accel_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] fused_pitch;

  // predictor copy of the registers and the integrated angle
  longint gyro_ofs, ay_ofs, az_ofs, out_bias;
  longint step_gain, blend, window;
  longint angle;

  logic signed [31:0] pitch_expected_q[$];
  int     mismatches = 0;
  longint cycles = 0;

  // sender burst shaping and receiver stall pattern
  int burst_left = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  imu_pitch_complementary_filter_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .gyro_rate(gyro_rate), .accel_y(accel_y), .accel_z(accel_z),
    .out_valid(out_valid), .out_stall(out_stall), .fused_pitch(fused_pitch)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("imu_pitch_complementary_filter_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint sext(longint v, int w);
    longint m;
    m = (64'sd1 <<< w) - 1;
    v = v & m;
    if (v[w-1]) v = v - (64'sd1 <<< w);
    return v;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // -atan2(y, z) in q16 degrees, cordic vectoring, clamped to +-90
  function automatic longint accel_tilt(longint y, longint z);
    longint x, v, a, t;
    int i;
    if (y == 0 && z == 0) return 0;
    x = z * 256;
    v = y * 256;
    a = 0;
    // left half plane: reflect and start from +-180
    if (x < 0) begin
      a = (y >= 0) ? TILT_180 : -TILT_180;
      x = -x;
      v = -v;
    end
    for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      t = x;
      if (v > 0) begin
        x = x + (v >>> i);
        v = v - (t >>> i);
        a = a + ATAN_TBL[i];
      end else begin
        x = x - (v >>> i);
        v = v + (t >>> i);
        a = a - ATAN_TBL[i];
      end
    end
    a = -((a * RAD_TO_DEG) >>> 30);
    if (a > TILT_90) a = TILT_90;
    if (a < -TILT_90) a = -TILT_90;
    return a;
  endfunction

  function automatic logic signed [31:0] predict_pitch(sample_t s);
    longint rate, ya, za, acc, err;
    rate = longint'(s.gyro) * 16 - gyro_ofs;
    angle = clip32(angle + ((rate * step_gain + 2048) >>> 12));
    ya = longint'(s.ay) * 16 - ay_ofs;
    za = longint'(s.az) * 16 - az_ofs;
    acc = accel_tilt(ya, za);
    // keep the accel tilt within the window around the integrated angle
    if (acc >= angle + window) acc = angle + window;
    else if (acc <= angle - window) acc = angle - window;
    err = acc - angle;
    angle = clip32(angle + ((err * blend + 32768) >>> 16));
    return 32'(clip32(angle + out_bias));
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_GYRO_OFFSET:  gyro_ofs  = sext(val, 20);
      REG_ACCEL_Y_OFS:  ay_ofs    = sext(val, 20);
      REG_ACCEL_Z_OFS:  az_ofs    = sext(val, 20);
      REG_GYRO_GAIN:    step_gain = val & 32'hFFFFFF;
      REG_BLEND_GAIN:   blend     = val & 32'hFFFF;
      REG_CLAMP_WINDOW: window    = val & 32'h7FFFFF;
      REG_OUTPUT_BIAS:  out_bias  = sext(val, 24);
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------ result check

  task automatic report(string what, longint got, longint want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pitch_expected_q.size() == 0) begin
        report("unexpected item, fused_pitch", fused_pitch, 0);
      end else begin
        if (fused_pitch !== pitch_expected_q[0])
          report("fused_pitch", fused_pitch, pitch_expected_q[0]);
        void'(pitch_expected_q.pop_front());
      end
    end
  end

  // receiver: random stall pattern, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ------------------------------------------------------------ driver tasks

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    apply_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_sample(sample_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    gyro_rate <= s.gyro;
    accel_y <= s.ay;
    accel_z <= s.az;
    do @(posedge clk); while (in_stall);
    pitch_expected_q.push_back(predict_pitch(s));
  endtask

  // drain: stop sending, wait until all results are in, then idle
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pitch_expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send(int g, int y, int z);
    sample_t s;
    s.gyro = 16'(g);
    s.ay = 16'(y);
    s.az = 16'(z);
    send_sample(s);
  endtask

  // mostly plausible motion, some full-range noise
  function automatic sample_t rand_sample();
    sample_t s;
    if ($urandom_range(0, 99) < 45) begin
      s.gyro = 16'($urandom);
      s.ay = 16'($urandom);
      s.az = 16'($urandom);
    end else begin
      s.gyro = 16'($urandom_range(0, 1200) - 600);
      s.ay = 16'($urandom_range(0, 33000) - 16500);
      s.az = 16'($urandom_range(0, 33000) - 16500);
    end
    return s;
  endfunction

  task automatic write_all(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                           logic [31:0] v3, logic [31:0] v4, logic [31:0] v5,
                           logic [31:0] v6);
    cfg_write(REG_GYRO_OFFSET, v0);
    cfg_write(REG_ACCEL_Y_OFS, v1);
    cfg_write(REG_ACCEL_Z_OFS, v2);
    cfg_write(REG_GYRO_GAIN, v3);
    cfg_write(REG_BLEND_GAIN, v4);
    cfg_write(REG_CLAMP_WINDOW, v5);
    cfg_write(REG_OUTPUT_BIAS, v6);
  endtask

  // -------------------------------------------------------------- test tasks

  // reset defaults and field extremes
  task automatic test_defaults();
    gap_max = 3;
    stall_pct = 20;
    send(0, 0, 0);
    send(32767, 32767, 32767);
    send(-32768, -32768, -32768);
    send(32767, -32768, 32767);
    send(-32768, 32767, -32768);
    send(100, 0, 16384);
    wait_drained();
  endtask

  // zero accel vector, the +-180 reflection, +-90 clamp and window clamp
  task automatic test_tilt_cases();
    write_all(0, 0, 0, 10230, 65535, 32'h7FFFFF, 0);
    send(0, 0, 0);
    send(0, 0, -1000);
    send(0, -1, -1000);
    send(0, 1, -1000);
    send(0, 16384, 0);
    send(0, -16384, 0);
    send(0, -16384, 16384);
    wait_drained();
    cfg_write(REG_CLAMP_WINDOW, 65536);
    cfg_write(REG_UNUSED, 32'hFFFFFFFF);
    send(0, 16384, 1);
    send(0, -16384, 1);
    send(0, 0, 16384);
    wait_drained();
  endtask

  // angle register and output sum saturate both ways
  task automatic test_saturation();
    write_all(0, 0, 0, 32'hFFFFFF, 0, 0, 32'h5A0000);
    send(32767, 0, 100);
    send(32767, 0, 100);
    send(-32768, 0, 100);
    send(-32768, 0, 100);
    send(-32768, 0, 100);
    wait_drained();
    cfg_write(REG_OUTPUT_BIAS, 32'hFFA60000);
    send(-32768, 0, 100);
    send(32767, 0, 100);
    wait_drained();
  endtask

  // register settings from extreme to random, items under each
  task automatic test_settings();
    int k, n;
    gap_max = 6;
    stall_pct = 30;
    for (k = 0; k < 7; k++) begin
      case (k)
        0: write_all(0, 0, 0, 0, 0, 0, 0);
        1: write_all(32'h7FFFF, 32'h7FFFF, 32'h7FFFF, 32'hFFFFFF, 32'hFFFF,
                     32'h7FFFFF, 32'h7FFFFF);
        2: write_all(32'h80000, 32'h80000, 32'h80000, 0, 0, 0, 32'h800000);
        3: write_all(24, 24, 160, 10230, 328, 655360, 32'hFFFC0000);
        default: write_all($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
      endcase
      for (n = 0; n < 80; n++) send_sample(rand_sample());
      wait_drained();
    end
  endtask

  // long random run with mixed sender and receiver idling
  task automatic test_random();
    int n;
    write_all(24, 24, 160, $urandom_range(0, 200000), $urandom_range(0, 8000),
              $urandom_range(0, 5898240), $urandom_range(0, 11796480) - 5898240);
    for (n = 0; n < 1000; n++) begin
      if (n % 125 == 0) begin
        gap_max = (n % 250 == 0) ? 0 : $urandom_range(1, 30);
        stall_pct = (n % 375 == 0) ? 0 : $urandom_range(10, 80);
      end
      send_sample(rand_sample());
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_hold_off();
    int n;
    gap_max = 0;
    stall_pct = 0;
    hold_req = 400;
    for (n = 0; n < 60; n++) send_sample(rand_sample());
    wait_drained();
  endtask

  initial begin
    gyro_ofs = 24;
    ay_ofs = 24;
    az_ofs = 160;
    step_gain = 10230;
    blend = 328;
    window = 655360;
    out_bias = -262144;
    angle = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_tilt_cases();
    test_saturation();
    test_settings();
    test_random();
    test_hold_off();

    wait_drained();
    if (mismatches == 0) begin
      $display("imu_pitch_complementary_filter_core test passed");
    end else begin
      $display("imu_pitch_complementary_filter_core test failed");
    end
    $finish;
  end

endmodule
